// ===== hdl/clist_pkg.sv =====
// Shared types and constants for the circular ordered list.
package clist_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int DATA_W       = 32;

  typedef enum logic [1:0] {
    MODE_FRONT  = 2'd0,
    MODE_BACK   = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_SHOW   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DELETED  = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_FULL     = 3'd4,
    ST_SHOWN    = 3'd5
  } status_t;

  typedef struct packed {
    logic take;
    logic give;
  } slot_op_t;

endpackage

// ===== hdl/clist_ram.sv =====
// Generic simple dual-port RAM with registered read.
module clist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/clist_slots.sv =====
// Free-slot tracker with lowest-free-slot selection.
module clist_slots #(
  parameter int CAPACITY = clist_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  clist_pkg::slot_op_t         op,
  input  logic [$clog2(CAPACITY)-1:0] give_slot,
  output logic [$clog2(CAPACITY)-1:0] low_slot
);

  localparam int SW = $clog2(CAPACITY);

  logic [CAPACITY-1:0] free;

  always_comb begin
    low_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free[i]) begin
        low_slot = SW'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free <= '1;
    end else begin
      if (op.take) begin
        free[low_slot] <= 1'b0;
      end
      if (op.give) begin
        free[give_slot] <= 1'b1;
      end
    end
  end

endmodule

// ===== hdl/circular_ordered_list.sv =====
// Circular ordered list: slot memories, link walker and operation sequencer.
// Insert on an empty or full list answers in idle, else S_INS_TAIL links the tail.
// Delete and display walk one linked entry per cycle through the registered
// read port of the slot RAMs, in the S_WALK state.
// busy drops in the cycle of the final result; results cannot stall.
// Synchronous reset empties the list and frees all slots; the RAMs are not cleared.
module circular_ordered_list #(
  parameter int CAPACITY = clist_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          mode,
  input  logic signed [clist_pkg::DATA_W-1:0] value,
  output logic                                valid,
  output logic [2:0]                          status,
  output logic signed [clist_pkg::DATA_W-1:0] entry,
  output logic                                last
);

  localparam int SW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = clist_pkg::DATA_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS_TAIL,
    S_WALK
  } state_t;

  state_t           state;
  clist_pkg::mode_t op;
  logic [DW-1:0]    val;
  logic [SW-1:0]    head;
  logic [SW-1:0]    tail;
  logic [SW-1:0]    cur;
  logic [SW-1:0]    prev;
  logic [SW-1:0]    new_slot;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;

  logic             accept;
  logic             is_ins;
  logic             full;
  logic             hit;
  logic             at_end;
  logic [SW-1:0]    low_slot;
  logic [SW-1:0]    rd_addr;
  logic [DW-1:0]    vals_rd;
  logic [SW-1:0]    links_rd;
  logic             vals_we;
  logic             links_we;
  logic [SW-1:0]    links_waddr;
  logic [SW-1:0]    links_wdata;
  clist_pkg::slot_op_t slot_op;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign is_ins = (clist_pkg::mode_t'(mode) == clist_pkg::MODE_FRONT) ||
                  (clist_pkg::mode_t'(mode) == clist_pkg::MODE_BACK);
  assign full   = (count == CW'(CAPACITY));
  assign hit    = (vals_rd == val);
  assign at_end = (idx == CW'(count - 1'b1));

  assign vals_we      = accept && is_ins && !full;
  assign slot_op.take = vals_we;
  assign slot_op.give = (state == S_WALK) && (op == clist_pkg::MODE_DELETE) && hit;

  always_comb begin
    links_we    = 1'b0;
    links_waddr = low_slot;
    links_wdata = head;
    rd_addr     = head;
    unique case (state)
      S_IDLE: begin
        if (vals_we) begin
          links_we    = 1'b1;
          links_wdata = (count == '0) ? low_slot : head;
        end
      end
      S_INS_TAIL: begin
        links_we    = 1'b1;
        links_waddr = tail;
        links_wdata = new_slot;
      end
      S_WALK: begin
        rd_addr = links_rd;
        if (slot_op.give && (count != CW'(1))) begin
          links_we    = 1'b1;
          links_waddr = prev;
          links_wdata = links_rd;
        end
      end
      default: begin
        rd_addr = head;
      end
    endcase
  end

  clist_ram #(
    .WIDTH(DW),
    .DEPTH(CAPACITY)
  ) u_vals (
    .clk  (clk),
    .we   (vals_we),
    .waddr(low_slot),
    .wdata(value),
    .raddr(rd_addr),
    .rdata(vals_rd)
  );

  clist_ram #(
    .WIDTH(SW),
    .DEPTH(CAPACITY)
  ) u_links (
    .clk  (clk),
    .we   (links_we),
    .waddr(links_waddr),
    .wdata(links_wdata),
    .raddr(rd_addr),
    .rdata(links_rd)
  );

  clist_slots #(
    .CAPACITY(CAPACITY)
  ) u_slots (
    .clk      (clk),
    .rst      (rst),
    .op       (slot_op),
    .give_slot(cur),
    .low_slot (low_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op     <= clist_pkg::mode_t'(mode);
            val    <= value;
            cur    <= head;
            prev   <= tail;
            idx    <= '0;
            status <= clist_pkg::ST_INSERTED;
            entry  <= '0;
            last   <= 1'b1;
            unique case (clist_pkg::mode_t'(mode)) inside
              clist_pkg::MODE_FRONT, clist_pkg::MODE_BACK: begin
                if (full) begin
                  valid  <= 1'b1;
                  status <= clist_pkg::ST_FULL;
                end else if (count == '0) begin
                  head  <= low_slot;
                  tail  <= low_slot;
                  count <= count + 1'b1;
                  valid <= 1'b1;
                end else begin
                  new_slot <= low_slot;
                  state    <= S_INS_TAIL;
                end
              end
              default: begin
                if (count == '0) begin
                  valid  <= 1'b1;
                  status <= clist_pkg::ST_EMPTY;
                end else begin
                  state <= S_WALK;
                end
              end
            endcase
          end
        end
        S_INS_TAIL: begin
          if (op == clist_pkg::MODE_BACK) begin
            tail <= new_slot;
          end else begin
            head <= new_slot;
          end
          count  <= count + 1'b1;
          valid  <= 1'b1;
          status <= clist_pkg::ST_INSERTED;
          entry  <= '0;
          last   <= 1'b1;
          state  <= S_IDLE;
        end
        S_WALK: begin
          prev <= cur;
          cur  <= links_rd;
          idx  <= idx + 1'b1;
          if (op == clist_pkg::MODE_SHOW) begin
            valid  <= 1'b1;
            status <= clist_pkg::ST_SHOWN;
            entry  <= vals_rd;
            last   <= at_end;
            if (at_end) begin
              state <= S_IDLE;
            end
          end else if (hit) begin
            if (count == CW'(1)) begin
              head <= '0;
              tail <= '0;
            end else begin
              if (cur == head) begin
                head <= links_rd;
              end
              if (cur == tail) begin
                tail <= prev;
              end
            end
            count  <= count - 1'b1;
            valid  <= 1'b1;
            status <= clist_pkg::ST_DELETED;
            entry  <= '0;
            last   <= 1'b1;
            state  <= S_IDLE;
          end else if (at_end) begin
            valid  <= 1'b1;
            status <= clist_pkg::ST_NOTFOUND;
            entry  <= '0;
            last   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    accept && !(is_ins && (full || count == '0)) &&
    !(!is_ins && count == '0) |=> busy)
    else $error("multi-cycle operation did not raise busy");

  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy)
    else $error("non-final result while idle");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    valid && (status == clist_pkg::ST_EMPTY) |-> count == '0)
    else $error("empty status with entries present");

endmodule
